// ----- src/rat_pkg.sv -----
// rational accumulator shared types and codes
// no dependencies
`timescale 1ns / 1ps
package rat_pkg;
    typedef enum logic [2:0] {
        OP_LOAD = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2,
        OP_MUL = 3'd3, OP_DIV = 3'd4, OP_CMP = 3'd5
    } t_opcode;
    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_BAD_DEN = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;
    // controller to datapath commands
    typedef struct packed {
        logic load_in;    // latch operand, compute cross products
        logic sum_step;   // form numerator/denominator candidates
        logic gcd_init;   // start euclid
        logic gcd_step;   // one restoring-divide bit step
        logic div_init;   // start exact divisions by gcd
        logic div_step;
        logic finish;     // check range, commit, form result
    } t_cmd;
    // datapath to controller status
    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic bitcnt_last;
    } t_stat;
endpackage

// ----- src/rat_datapath.sv -----
// rational accumulator datapath: products, euclid gcd and exact division
// depends on rat_pkg
`timescale 1ns / 1ps
module rat_datapath #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rat_pkg::t_cmd       i_cmd,
    output rat_pkg::t_stat      o_stat,
    input  logic [2:0]          i_opcode,
    input  logic signed [31:0]  i_operand_num,
    input  logic [30:0]         i_operand_den,
    output logic signed [31:0]  o_result_num,
    output logic [30:0]         o_result_den,
    output logic                o_is_equal,
    output logic [1:0]          o_error_code
);
    localparam int EW = (W > 32) ? 32 : ((W < 2) ? 2 : W);
    localparam logic [63:0] LIM = 64'd1 << (EW - 1);

    logic signed [31:0] r_acc_n;
    logic [30:0]        r_acc_d;
    logic [2:0]         r_op;
    logic signed [31:0] r_c;
    logic [30:0]        r_d;
    logic signed [63:0] r_ad, r_cb;
    logic signed [63:0] r_ac;
    logic [63:0]        r_mag, r_den;
    logic               r_neg;
    logic [1:0]         r_pre_err;
    logic               r_eq;
    // euclid and divider registers
    logic [63:0] r_x, r_y, r_q, r_rem, r_dvs;
    logic [5:0]  r_bit;
    logic        r_div_sel;    // 0 dividing magnitude, 1 dividing denominator
    logic        r_div_mode;   // 0 gcd modulo, 1 exact division
    logic [63:0] r_qm;

    logic [64:0] w_trial;
    logic [63:0] w_rsh;
    logic [63:0] w_nrem;
    logic signed [63:0] w_ncand;

    assign w_rsh   = {r_rem[62:0], r_q[63]};
    assign w_trial = {1'b0, w_rsh} - {1'b0, r_dvs};
    assign w_nrem  = w_trial[64] ? w_rsh : w_trial[63:0];

    always_comb begin
        case (r_op)
            rat_pkg::OP_LOAD: w_ncand = 64'(r_c);
            rat_pkg::OP_ADD:  w_ncand = r_ad + r_cb;
            rat_pkg::OP_SUB:  w_ncand = r_ad - r_cb;
            rat_pkg::OP_MUL:  w_ncand = r_ac;
            rat_pkg::OP_DIV:  w_ncand = r_c[31] ? -r_ad : r_ad;
            default:          w_ncand = 64'sd0;
        endcase
    end

    assign o_stat.gcd_done    = (r_y == 64'd0);
    assign o_stat.div_done    = r_div_sel;
    assign o_stat.bitcnt_last = (r_bit == 6'd63);

    // accumulator commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_n <= 32'sd0;
            r_acc_d <= 31'd1;
        end else if (i_cmd.finish && r_pre_err == rat_pkg::ERR_OK &&
                     r_op <= rat_pkg::OP_DIV) begin
            logic [63:0] m, dd;
            logic ng;
            m  = r_qm;
            dd = r_q;
            ng = r_neg;
            if (m == 64'd0) begin
                dd = 64'd1;
                ng = 1'b0;
            end
            if (!(dd >= LIM || (ng ? (m > LIM) : (m >= LIM)))) begin
                r_acc_n <= ng ? -32'(m) : 32'(m);
                r_acc_d <= 31'(dd);
            end
        end
    end

    // product, gcd and divide sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_opcode;
            r_c  <= i_operand_num;
            r_d  <= i_operand_den;
            r_ad <= 64'(r_acc_n) * $signed({33'd0, i_operand_den});
            r_cb <= 64'(i_operand_num) * $signed({33'd0, r_acc_d});
            r_ac <= 64'(r_acc_n) * 64'(i_operand_num);
            r_eq <= 1'b0;
            if (i_operand_den == 31'd0 && i_opcode <= rat_pkg::OP_CMP)
                r_pre_err <= rat_pkg::ERR_BAD_DEN;
            else if (i_opcode == rat_pkg::OP_DIV && i_operand_num == 32'sd0)
                r_pre_err <= rat_pkg::ERR_DIV_ZERO;
            else
                r_pre_err <= rat_pkg::ERR_OK;
        end
        if (i_cmd.sum_step) begin
            r_neg <= w_ncand[63];
            r_mag <= w_ncand[63] ? 64'(-w_ncand) : 64'(w_ncand);
            case (r_op)
                rat_pkg::OP_LOAD: r_den <= {33'd0, r_d};
                rat_pkg::OP_DIV:  r_den <= 64'({33'd0, r_acc_d}) *
                                   64'(r_c[31] ? -64'(r_c) : 64'(r_c));
                default:          r_den <= {33'd0, r_acc_d} * {33'd0, r_d};
            endcase
            r_eq <= (r_op == rat_pkg::OP_CMP) && (r_ad == r_cb);
        end
        if (i_cmd.gcd_init) begin
            r_x <= r_mag;
            r_y <= r_den;
            r_q <= r_mag;
            r_rem <= 64'd0;
            r_dvs <= r_den;
            r_bit <= 6'd0;
            r_div_mode <= 1'b0;
            r_div_sel <= 1'b0;
        end
        if (i_cmd.gcd_step || i_cmd.div_step) begin
            r_bit <= r_bit + 6'd1;
            if (r_bit != 6'd63) begin
                r_rem <= w_nrem;
                r_q   <= {r_q[62:0], ~w_trial[64]};
            end else if (!r_div_mode) begin
                // next euclid round: x <- y, y <- x mod y
                r_x   <= r_y;
                r_y   <= w_nrem;
                r_q   <= r_y;
                r_dvs <= w_nrem;
                r_rem <= 64'd0;
            end else begin
                r_qm      <= r_div_sel ? r_qm : {r_q[62:0], ~w_trial[64]};
                r_div_sel <= 1'b1;
                r_q       <= r_div_sel ? {r_q[62:0], ~w_trial[64]} : r_den;
                r_rem     <= 64'd0;
            end
        end
        if (i_cmd.div_init) begin
            r_dvs <= (r_x == 64'd0) ? 64'd1 : r_x;
            r_q <= r_mag;
            r_rem <= 64'd0;
            r_bit <= 6'd0;
            r_div_mode <= 1'b1;
            r_div_sel <= 1'b0;
        end
    end

    // result formation
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            logic [63:0] m, dd;
            logic ng, ovf;
            m  = r_qm;
            dd = r_q;
            ng = r_neg;
            if (m == 64'd0) begin
                dd = 64'd1;
                ng = 1'b0;
            end
            ovf = dd >= LIM || (ng ? (m > LIM) : (m >= LIM));
            o_is_equal <= 1'b0;
            if (r_pre_err != rat_pkg::ERR_OK) begin
                o_error_code <= r_pre_err;
                o_result_num <= r_acc_n;
                o_result_den <= r_acc_d;
            end else if (r_op > rat_pkg::OP_DIV) begin
                o_error_code <= rat_pkg::ERR_OK;
                o_is_equal   <= r_eq;
                o_result_num <= r_acc_n;
                o_result_den <= r_acc_d;
            end else if (ovf) begin
                o_error_code <= rat_pkg::ERR_OVERFLOW;
                o_result_num <= r_acc_n;
                o_result_den <= r_acc_d;
            end else begin
                o_error_code <= rat_pkg::ERR_OK;
                o_result_num <= ng ? -32'(m) : 32'(m);
                o_result_den <= 31'(dd);
            end
        end
    end
endmodule

// ----- src/rat_ctrl.sv -----
// rational accumulator controller state machine
// depends on rat_pkg
`timescale 1ns / 1ps
module rat_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  logic [2:0]     i_opcode,
    output rat_pkg::t_cmd  o_cmd,
    input  rat_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_GINIT, S_GCD, S_DINIT, S_DIV, S_FIN, S_OUT
    } t_state;
    t_state r_state;
    logic   r_valid;
    logic   r_fast;

    assign o_stall = (r_state != S_IDLE) || (r_valid && i_stall);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_in  = (r_state == S_IDLE) && i_valid && !o_stall;
        o_cmd.sum_step = (r_state == S_SUM);
        o_cmd.gcd_init = (r_state == S_GINIT);
        o_cmd.gcd_step = (r_state == S_GCD) && !i_stat.gcd_done;
        o_cmd.div_init = (r_state == S_DINIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_FIN);
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_fast  <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_cmd.load_in) begin
                    r_state <= S_SUM;
                    r_fast  <= i_opcode > rat_pkg::OP_DIV;
                end
                S_SUM:   r_state <= r_fast ? S_FIN : S_GINIT;
                S_GINIT: r_state <= S_GCD;
                S_GCD:   if (i_stat.gcd_done) r_state <= S_DINIT;
                S_DINIT: r_state <= S_DIV;
                S_DIV:   if (i_stat.div_done && i_stat.bitcnt_last) r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/rational_accumulator_alu_unit.sv -----
// rational accumulator alu: one transaction in flight, euclid gcd reduce
// load/add/sub/mul/div: R euclid rounds of the 64-step bit-serial remainder, then
// the two exact divides of magnitude and denominator by the gcd
// compare and opcodes 6, 7 skip gcd and divides; next input only after the result
// reset (synchronous, active low) sets accumulator to 0/1 and clears valid
// depends on rat_pkg, rat_ctrl, rat_datapath
`timescale 1ns / 1ps
module rational_accumulator_alu_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_operand_num,
    input  logic [30:0]        i_operand_den,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_num,
    output logic [30:0]        o_result_den,
    output logic               o_is_equal,
    output logic [1:0]         o_error_code
);
    rat_pkg::t_cmd  w_cmd;
    rat_pkg::t_stat w_stat;

    rat_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_opcode, .o_cmd(w_cmd), .i_stat(w_stat)
    );

    rat_datapath #(.W(DATA_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_opcode, .i_operand_num, .i_operand_den,
        .o_result_num, .o_result_den, .o_is_equal, .o_error_code
    );

    // denominator of a delivered result is never zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_den != 31'd0) else $error("zero denominator");
    // equality flag only comes with no error
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_equal |-> o_error_code == rat_pkg::ERR_OK)
        else $error("equal with error");
endmodule
